[design/nv21_pkg.sv]
package nv21_pkg;

    localparam int MAX_DIM_BITS_DEF = 12;

    localparam int PIX_W   = 8;
    localparam int WORD_W  = 32;
    localparam int CFG_W   = 13;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;
    localparam int COLOR_W = 12;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 13'd640;
    localparam logic [CFG_W-1:0] LINE_COUNT_RESET = 13'd480;
    localparam logic [PIX_W-1:0] ALPHA_OPAQUE     = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_MAX          = 8'd255;

    // register index, taken from paddr[2]
    localparam logic REG_LINE_WIDTH = 1'b0;
    localparam logic REG_LINE_COUNT = 1'b1;

    // clamp a signed intermediate to 0..255
    function automatic logic [PIX_W-1:0] sat8(input logic signed [COLOR_W-1:0] v);
        logic [PIX_W-1:0] res;
        if (v < 0)
            res = '0;
        else if (v > $signed({{(COLOR_W-PIX_W){1'b0}}, PIX_MAX}))
            res = PIX_MAX;
        else
            res = v[PIX_W-1:0];
        return res;
    endfunction

    // unsigned chroma byte minus 128 as a signed byte
    function automatic logic signed [PIX_W-1:0] center(input logic [PIX_W-1:0] c);
        return $signed({~c[PIX_W-1], c[PIX_W-2:0]});
    endfunction

endpackage

[design/nv21_pix_in_if.sv]
interface nv21_pix_in_if
    import nv21_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;

    modport source (output valid, output luma, output chroma_blue, output chroma_red,
                    input ready);
    modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                    output ready);
endinterface

[design/nv21_pix_out_if.sv]
interface nv21_pix_out_if
    import nv21_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] pixel_word;
    logic              frame_end;

    modport source (output valid, output pixel_word, output frame_end, input ready);
    modport sink   (input valid, input pixel_word, input frame_end, output ready);
endinterface

[design/nv21_color.sv]
module nv21_color
    import nv21_pkg::*;
(
    input  logic [PIX_W-1:0]        luma,
    input  logic signed [PIX_W-1:0] cb,
    input  logic signed [PIX_W-1:0] cr,
    output logic [WORD_W-1:0]       pixel_word
);

    localparam int EXT = COLOR_W - PIX_W;

    logic signed [COLOR_W-1:0] ys;
    logic signed [COLOR_W-1:0] cb_w;
    logic signed [COLOR_W-1:0] cr_w;
    logic signed [COLOR_W-1:0] r_sum;
    logic signed [COLOR_W-1:0] g_sum;
    logic signed [COLOR_W-1:0] b_sum;

    always_comb
    begin
        // luma times 1 + 1/8 + 1/32 + 1/128
        ys = $signed({{EXT{1'b0}}, luma})
           + $signed({{(EXT+3){1'b0}}, luma[PIX_W-1:3]})
           + $signed({{(EXT+5){1'b0}}, luma[PIX_W-1:5]})
           + $signed({{(EXT+7){1'b0}}, luma[PIX_W-1:7]});
        cb_w = $signed({{EXT{cb[PIX_W-1]}}, cb});
        cr_w = $signed({{EXT{cr[PIX_W-1]}}, cr});
        r_sum = ys + cr_w + (cr_w >>> 1) + (cr_w >>> 4) + (cr_w >>> 5);
        g_sum = ys - cr_w + (cr_w >>> 3) + (cr_w >>> 4) - (cb_w >>> 1) + (cb_w >>> 3);
        b_sum = ys + (cb_w <<< 1) + (cb_w >>> 6);
        pixel_word = {ALPHA_OPAQUE, sat8(r_sum), sat8(g_sum), sat8(b_sum)};
    end

endmodule

[design/nv21_to_argb_pixel_converter.sv]
// NV21 pixel to opaque ARGB converter. Feed one pixel per transfer in raster order with its
// luma byte and the raw Cb/Cr bytes of its 2x2 block; chroma is latched on even columns and
// reused on odd ones, and column parity restarts at each line from line_width (APB offset 0)
// while line_count (offset 4) marks the last pixel of the frame with frame_end. A value of 0
// acts as 1 and a value above 2**MAX_DIM_BITS acts as 2**MAX_DIM_BITS. Each pixel passes an
// input register and a result register, so a result is offered from the result register once
// its pixel has moved on from the input register, and one pixel is accepted every cycle while
// the sink takes results, the rate set by the single shift-add color stage;
// the result register frees while its word waits only if the sink takes it.
module nv21_to_argb_pixel_converter
    import nv21_pkg::*;
#(
    parameter int MAX_DIM_BITS = MAX_DIM_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    nv21_pix_in_if.sink        pix_in,
    nv21_pix_out_if.source     pix_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready
);

    localparam int CMP_W = (MAX_DIM_BITS + 1 > CFG_W) ? MAX_DIM_BITS + 1 : CFG_W;
    localparam logic [CMP_W-1:0] DIM_LIMIT = CMP_W'(1) << MAX_DIM_BITS;

    logic [CFG_W-1:0] line_width_reg;
    logic [CFG_W-1:0] line_count_reg;

    logic [MAX_DIM_BITS-1:0] col_reg;
    logic [MAX_DIM_BITS-1:0] col_next;
    logic [MAX_DIM_BITS-1:0] row_reg;
    logic [MAX_DIM_BITS-1:0] row_next;
    logic signed [PIX_W-1:0] held_blue_reg;
    logic signed [PIX_W-1:0] held_red_reg;

    logic                    s1_valid_reg;
    logic [PIX_W-1:0]        s1_luma_reg;
    logic signed [PIX_W-1:0] s1_cb_reg;
    logic signed [PIX_W-1:0] s1_cr_reg;
    logic                    s1_frame_end_reg;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic              out_frame_end_reg;

    logic [CMP_W-1:0] width_raw;
    logic [CMP_W-1:0] count_raw;
    logic [CMP_W-1:0] width_eff;
    logic [CMP_W-1:0] count_eff;
    logic             last_col;
    logic             last_row;
    logic             in_fire;
    logic             out_adv;
    logic             s1_fire;
    logic             cfg_write;
    logic signed [PIX_W-1:0] cb_cur;
    logic signed [PIX_W-1:0] cr_cur;
    logic [WORD_W-1:0]       color_word;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
            line_count_reg <= LINE_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_LINE_WIDTH: line_width_reg <= pwdata[CFG_W-1:0];
                REG_LINE_COUNT: line_count_reg <= pwdata[CFG_W-1:0];
                default:        line_width_reg <= line_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_LINE_WIDTH: prdata = APB_W'(line_width_reg);
            REG_LINE_COUNT: prdata = APB_W'(line_count_reg);
            default:        prdata = '0;
        endcase
    end

    // effective dimensions and position
    always_comb
    begin
        width_raw = CMP_W'(line_width_reg);
        count_raw = CMP_W'(line_count_reg);
        if (width_raw == '0)
            width_eff = CMP_W'(1);
        else if (width_raw > DIM_LIMIT)
            width_eff = DIM_LIMIT;
        else
            width_eff = width_raw;
        if (count_raw == '0)
            count_eff = CMP_W'(1);
        else if (count_raw > DIM_LIMIT)
            count_eff = DIM_LIMIT;
        else
            count_eff = count_raw;
        last_col = (CMP_W'(col_reg) + CMP_W'(1)) >= width_eff;
        last_row = (CMP_W'(row_reg) + CMP_W'(1)) >= count_eff;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + MAX_DIM_BITS'(1);
        end
        else
        begin
            col_next = col_reg + MAX_DIM_BITS'(1);
            row_next = row_reg;
        end
        cb_cur = col_reg[0] ? held_blue_reg : center(pix_in.chroma_blue);
        cr_cur = col_reg[0] ? held_red_reg  : center(pix_in.chroma_red);
    end

    // handshake: two register stages, each frees when the next one moves
    assign out_adv      = !out_valid_reg || pix_out.ready;
    assign s1_fire      = s1_valid_reg && out_adv;
    assign pix_in.ready = !s1_valid_reg || out_adv;
    assign in_fire      = pix_in.valid && pix_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            held_blue_reg <= '0;
            held_red_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                col_reg       <= col_next;
                row_reg       <= row_next;
                held_blue_reg <= cb_cur;
                held_red_reg  <= cr_cur;
                s1_valid_reg  <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (pix_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_luma_reg      <= pix_in.luma;
            s1_cb_reg        <= cb_cur;
            s1_cr_reg        <= cr_cur;
            s1_frame_end_reg <= last_col && last_row;
        end
        if (s1_fire)
        begin
            out_word_reg      <= color_word;
            out_frame_end_reg <= s1_frame_end_reg;
        end
    end

    nv21_color u_color (
        .luma       (s1_luma_reg),
        .cb         (s1_cb_reg),
        .cr         (s1_cr_reg),
        .pixel_word (color_word)
    );

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.pixel_word = out_word_reg;
    assign pix_out.frame_end  = out_frame_end_reg;

    // odd columns must reuse the chroma latched on the even column
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && col_reg[0] |=> s1_cb_reg == $past(held_blue_reg)
                                  && s1_cr_reg == $past(held_red_reg))
        else $error("odd column did not reuse held chroma");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_col && last_row |=> col_reg == '0 && row_reg == '0
                                            && s1_frame_end_reg)
        else $error("frame end did not restart position");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg && out_word_reg == $past(color_word))
        else $error("input stage transfer lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pix_out.ready |-> !s1_fire)
        else $error("result register overwritten while stalled");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import nv21_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1230;
    localparam int PRINT_CAP    = 40;

    typedef struct packed {
        logic [WORD_W-1:0] pixel_word;
        logic              frame_end;
    } argb_result_t;

    class argb_scoreboard;
        argb_result_t expected_words[$];
        int           error_count;
        int unsigned  width_setting;
        int unsigned  count_setting;
        int unsigned  col_pos;
        int unsigned  row_pos;
        int           blue_diff;
        int           red_diff;

        function new();
            error_count   = 0;
            width_setting = 32'(LINE_WIDTH_RESET);
            count_setting = 32'(LINE_COUNT_RESET);
            col_pos       = 0;
            row_pos       = 0;
            blue_diff     = 0;
            red_diff      = 0;
        endfunction

        function void set_register(logic sel, logic [APB_W-1:0] value);
            if (sel == REG_LINE_WIDTH)
                width_setting = 32'(value[CFG_W-1:0]);
            else
                count_setting = 32'(value[CFG_W-1:0]);
        endfunction

        // 0 acts as 1, anything past the counter range acts as its top
        function int unsigned usable_dim(int unsigned v);
            int unsigned top;
            top = 1 << MAX_DIM_BITS_DEF;
            if (v == 0)
                return 1;
            else if (v > top)
                return top;
            else
                return v;
        endfunction

        function logic [PIX_W-1:0] clamp_channel(int v);
            if (v < 0)
                return '0;
            else if (v > 255)
                return PIX_MAX;
            else
                return v[PIX_W-1:0];
        endfunction

        function void note_pixel(logic [PIX_W-1:0] y, logic [PIX_W-1:0] cb,
                                 logic [PIX_W-1:0] cr);
            int           yi;
            int           ys;
            int           r;
            int           g;
            int           b;
            int unsigned  w;
            int unsigned  h;
            logic         last_col;
            logic         last_row;
            argb_result_t res;
            w = usable_dim(width_setting);
            h = usable_dim(count_setting);
            // chroma pair is taken on even columns and reused on odd ones
            if (col_pos[0] == 1'b0)
            begin
                blue_diff = int'(cb) - 128;
                red_diff  = int'(cr) - 128;
            end
            yi = int'(y);
            ys = yi + (yi >> 3) + (yi >> 5) + (yi >> 7);
            r  = ys + red_diff + (red_diff >>> 1) + (red_diff >>> 4) + (red_diff >>> 5);
            g  = ys - red_diff + (red_diff >>> 3) + (red_diff >>> 4)
                 - (blue_diff >>> 1) + (blue_diff >>> 3);
            b  = ys + 2 * blue_diff + (blue_diff >>> 6);
            res.pixel_word = {ALPHA_OPAQUE, clamp_channel(r), clamp_channel(g),
                              clamp_channel(b)};
            last_col = (col_pos + 1) >= w;
            last_row = (row_pos + 1) >= h;
            res.frame_end = last_col && last_row;
            expected_words = {expected_words, res};
            if (last_col)
            begin
                col_pos = 0;
                row_pos = last_row ? 0 : row_pos + 1;
            end
            else
                col_pos = col_pos + 1;
        endfunction

        task report_mismatch(string what);
            error_count++;
            if (error_count <= PRINT_CAP)
                $display("mismatch: %s", what);
        endtask

        task check_result(logic [WORD_W-1:0] word, logic last_pixel);
            argb_result_t want;
            if (expected_words.size() == 0)
                report_mismatch($sformatf("unexpected pixel %h frame_end %b", word, last_pixel));
            else
            begin
                want = expected_words.pop_front();
                if (word !== want.pixel_word)
                    report_mismatch($sformatf("pixel_word %h, predicted %h",
                                              word, want.pixel_word));
                if (last_pixel !== want.frame_end)
                    report_mismatch($sformatf("frame_end %b, predicted %b (pixel %h)",
                                              last_pixel, want.frame_end, want.pixel_word));
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_W-1:0]   pwdata;
    logic [APB_W-1:0]   prdata;
    logic               pready;

    nv21_pix_in_if  pix_in_bus ();
    nv21_pix_out_if pix_out_bus ();

    argb_scoreboard argb_sb;
    int             send_gap_max;
    int             take_gap_max;
    int             random_sent;

    logic [23:0] corner_pixels [18] = '{
        24'h00_00_00, 24'hFF_FF_FF, 24'hFF_00_00, 24'h00_FF_FF, 24'h80_80_80, 24'h00_80_80,
        24'hFF_80_80, 24'h10_00_FF, 24'hEB_FF_00, 24'h7F_7F_81, 24'h55_AA_55, 24'hAA_55_AA,
        24'h00_FF_00, 24'hFF_00_FF, 24'h01_01_FE, 24'hFE_FE_01, 24'h40_C0_40, 24'hC0_40_C0
    };

    nv21_to_argb_pixel_converter u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_bus),
        .pix_out (pix_out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [PIX_W-1:0] pick_byte();
        int unsigned k;
        k = $urandom_range(0, 7);
        if (k == 0)
            return '0;
        else if (k == 1)
            return PIX_MAX;
        else
            return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic int pick_gap_max();
        int unsigned k;
        k = $urandom_range(0, 3);
        if (k == 0)
            return 0;
        else if (k == 1)
            return 3;
        else
            return 15;
    endfunction

    // mostly short lines and frames so that wraps come often
    function automatic int unsigned pick_dim();
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k < 12)
            return $urandom_range(0, 8);
        else if (k < 17)
            return $urandom_range(9, 48);
        else if (k < 19)
            return $urandom_range(4096, 8191);
        else
            return 1;
    endfunction

    task automatic send_pixel(logic [PIX_W-1:0] y, logic [PIX_W-1:0] cb,
                              logic [PIX_W-1:0] cr);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            pix_in_bus.valid <= 1'b0;
            repeat (gap)
            begin
                pix_in_bus.luma        <= PIX_W'($urandom_range(0, 255));
                pix_in_bus.chroma_blue <= PIX_W'($urandom_range(0, 255));
                pix_in_bus.chroma_red  <= PIX_W'($urandom_range(0, 255));
                @(posedge clk);
            end
        end
        pix_in_bus.valid       <= 1'b1;
        pix_in_bus.luma        <= y;
        pix_in_bus.chroma_blue <= cb;
        pix_in_bus.chroma_red  <= cr;
        do @(posedge clk); while (!pix_in_bus.ready);
        argb_sb.note_pixel(y, cb, cr);
    endtask

    task automatic send_random(int count, bit paired_chroma);
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] cr;
        cb = '0;
        cr = '0;
        for (int i = 0; i < count; i++)
        begin
            // paired mode repeats chroma across each pixel pair as a real frame does
            if (!paired_chroma || i[0] == 1'b0)
            begin
                cb = pick_byte();
                cr = pick_byte();
            end
            send_pixel(pick_byte(), cb, cr);
        end
    endtask

    task automatic wait_drained();
        pix_in_bus.valid <= 1'b0;
        while (argb_sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic sel, int unsigned value);
        logic [APB_W-1:0] data;
        data = $urandom();
        data[CFG_W-1:0] = value[CFG_W-1:0];
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        argb_sb.set_register(sel, data);
    endtask

    task automatic set_frame(int unsigned w, int unsigned h);
        write_register(REG_LINE_WIDTH, w);
        write_register(REG_LINE_COUNT, h);
    endtask

    // result side: random stalls, accepts whatever the block offers
    initial
    begin
        int gap;
        pix_out_bus.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = $urandom_range(0, take_gap_max);
            if (gap > 0)
            begin
                pix_out_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pix_out_bus.ready <= 1'b1;
            do @(posedge clk); while (!pix_out_bus.valid);
            argb_sb.check_result(pix_out_bus.pixel_word, pix_out_bus.frame_end);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        int n;
        int unsigned k;
        argb_sb      = new();
        send_gap_max = 3;
        take_gap_max = 3;
        random_sent  = 0;
        rst_n                  <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        pix_in_bus.valid       <= 1'b0;
        pix_in_bus.luma        <= '0;
        pix_in_bus.chroma_blue <= '0;
        pix_in_bus.chroma_red  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner values at the reset frame size, odd columns reuse the even chroma
        foreach (corner_pixels[i])
            send_pixel(corner_pixels[i][23:16], corner_pixels[i][15:8], corner_pixels[i][7:0]);
        wait_drained();

        // width drops below the current column, so the next pixel ends the line
        set_frame(3, 2);
        send_random(30, 1'b0);
        wait_drained();

        // zero sizes: every pixel closes a frame
        set_frame(0, 0);
        send_random(20, 1'b1);
        wait_drained();

        // row past the end after the count shrinks
        set_frame(1, 8);
        send_random(5, 1'b0);
        wait_drained();
        write_register(REG_LINE_COUNT, 2);
        send_random(10, 1'b0);
        wait_drained();

        // oversized values clamp to the counter range
        set_frame(8191, 4097);
        send_random(24, 1'b1);
        wait_drained();

        while (random_sent < RANDOM_ITEMS)
        begin
            send_gap_max = pick_gap_max();
            take_gap_max = pick_gap_max();
            k = $urandom_range(0, 5);
            if (k < 4)
                set_frame(pick_dim(), pick_dim());
            else if (k == 4)
                write_register(REG_LINE_WIDTH, pick_dim());
            else
                write_register(REG_LINE_COUNT, pick_dim());
            n = $urandom_range(10, 80);
            send_random(n, 1'($urandom_range(0, 1)));
            random_sent += n;
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (argb_sb.error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

[files.f]
design/nv21_pkg.sv
design/nv21_pix_in_if.sv
design/nv21_pix_out_if.sv
design/nv21_color.sv
design/nv21_to_argb_pixel_converter.sv
tb/sv/tb_top.sv
